FILE: rtl/bfsp_pkg.sv
// Shared types, widths and codes for the Bellman-Ford shortest path block.
package bfsp_pkg;

  // Payload field widths
  localparam int unsigned SLOT_W      = 8;
  localparam int unsigned NODE_W      = 6;
  localparam int unsigned WEIGHT_BITS = 16;
  localparam int unsigned DIST_BITS   = 24;

  // Configuration register widths
  localparam int unsigned NCFG_W     = 7;
  localparam int unsigned ECFG_W     = 9;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;

  // Default sizes of the stores
  localparam int unsigned DEF_MAX_NODES = 64;
  localparam int unsigned DEF_MAX_EDGES = 256;

  // Distance reported for a node that was never reached
  localparam logic [DIST_BITS-1:0] UNREACHED_DIST = DIST_BITS'(100000);

  // Item kinds
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_RUN  = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_COUNT = CFG_IDX_W'(1);

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EDGE_RD,
    ST_DIST_RD,
    ST_RELAX,
    ST_PASS_END,
    ST_NODE_RD,
    ST_NODE_OUT,
    ST_NEG_OUT
  } bfsp_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load_edge;
    logic run_start;
    logic relax;
    logic pass_next;
    logic node_sel;
    logic node_load;
    logic neg_load;
  } bfsp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic edges_none;
    logic edge_last;
    logic check_pass;
    logic neg_found;
    logic node_last;
    logic out_free;
  } bfsp_sts_t;

endpackage

FILE: rtl/bfsp_in_if.sv
// Input item channel: edge loads and run requests.
interface bfsp_in_if;
  import bfsp_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   kind;
  logic [SLOT_W-1:0]      edge_slot;
  logic [NODE_W-1:0]      from_node;
  logic [NODE_W-1:0]      to_node;
  logic [WEIGHT_BITS-1:0] edge_weight;
  logic [NODE_W-1:0]      source_node;

  modport source (output valid, kind, edge_slot, from_node, to_node, edge_weight,
                  source_node, input ready);
  modport sink (input valid, kind, edge_slot, from_node, to_node, edge_weight,
                source_node, output ready);
endinterface

FILE: rtl/bfsp_out_if.sv
// Result item channel: per-node distances or a negative cycle flag.
interface bfsp_out_if;
  import bfsp_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [NODE_W-1:0]    node_index;
  logic [DIST_BITS-1:0] distance;
  logic                 reached;
  logic                 negative_cycle;
  logic                 last;

  modport source (output valid, node_index, distance, reached, negative_cycle, last,
                  input ready);
  modport sink (input valid, node_index, distance, reached, negative_cycle, last,
                output ready);
endinterface

FILE: rtl/bfsp_cfg_if.sv
// Configuration write channel: register index and write data.
interface bfsp_cfg_if;
  import bfsp_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wr_data;

  modport source (output valid, reg_index, wr_data, input ready);
  modport sink (input valid, reg_index, wr_data, output ready);
endinterface

FILE: rtl/bfsp_ctrl.sv
// Sequencer for edge loads, relaxation passes, the cycle check and result emission.
module bfsp_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_kind,
  output logic               in_ready,
  input  bfsp_pkg::bfsp_sts_t sts,
  output bfsp_pkg::bfsp_cmd_t cmd
);
  import bfsp_pkg::*;

  bfsp_state_t state_r;
  bfsp_state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_kind == KIND_RUN) begin
            cmd.run_start = 1'b1;
            state_nxt     = sts.edges_none ? ST_NODE_RD : ST_EDGE_RD;
          end else begin
            cmd.load_edge = 1'b1;
          end
        end
      end
      ST_EDGE_RD: begin
        state_nxt = ST_DIST_RD;
      end
      ST_DIST_RD: begin
        state_nxt = ST_RELAX;
      end
      ST_RELAX: begin
        cmd.relax = 1'b1;
        state_nxt = sts.edge_last ? ST_PASS_END : ST_EDGE_RD;
      end
      ST_PASS_END: begin
        if (sts.check_pass) begin
          state_nxt = sts.neg_found ? ST_NEG_OUT : ST_NODE_RD;
        end else begin
          cmd.pass_next = 1'b1;
          state_nxt     = ST_EDGE_RD;
        end
      end
      ST_NODE_RD: begin
        cmd.node_sel = 1'b1;
        state_nxt    = ST_NODE_OUT;
      end
      ST_NODE_OUT: begin
        cmd.node_sel = 1'b1;
        if (sts.out_free) begin
          cmd.node_load = 1'b1;
          state_nxt     = sts.node_last ? ST_IDLE : ST_NODE_RD;
        end
      end
      ST_NEG_OUT: begin
        if (sts.out_free) begin
          cmd.neg_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/bfsp_dp.sv
// Datapath: config registers, edge and distance memories, relax unit, output register.
module bfsp_dp #(
  parameter int unsigned MAX_NODES = bfsp_pkg::DEF_MAX_NODES,
  parameter int unsigned MAX_EDGES = bfsp_pkg::DEF_MAX_EDGES
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  bfsp_pkg::bfsp_cmd_t                cmd,
  output bfsp_pkg::bfsp_sts_t                sts,
  input  logic                               cfg_we,
  input  logic [bfsp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bfsp_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic [bfsp_pkg::SLOT_W-1:0]        in_slot,
  input  logic [bfsp_pkg::NODE_W-1:0]        in_from,
  input  logic [bfsp_pkg::NODE_W-1:0]        in_to,
  input  logic [bfsp_pkg::WEIGHT_BITS-1:0]   in_weight,
  input  logic [bfsp_pkg::NODE_W-1:0]        in_source,
  input  logic                               out_ready,
  output logic                               out_valid,
  output logic [bfsp_pkg::NODE_W-1:0]        out_node,
  output logic [bfsp_pkg::DIST_BITS-1:0]     out_dist,
  output logic                               out_reached,
  output logic                               out_neg,
  output logic                               out_last
);
  import bfsp_pkg::*;

  localparam int unsigned EA   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned NA   = $clog2(MAX_NODES);
  localparam int unsigned ECAP = (MAX_EDGES > 511) ? 511 : MAX_EDGES;

  typedef struct packed {
    logic [NODE_W-1:0]      tail;
    logic [NODE_W-1:0]      head;
    logic [WEIGHT_BITS-1:0] weight;
  } edge_t;

  logic [NCFG_W-1:0]    node_cnt_r;
  logic [ECFG_W-1:0]    edge_cnt_r;
  logic [NCFG_W-1:0]    n_eff;
  logic [ECFG_W-1:0]    e_eff;

  edge_t                edge_mem [MAX_EDGES];
  edge_t                edge_rd_r;
  logic [DIST_BITS-1:0] dist_mem [MAX_NODES];
  logic [DIST_BITS-1:0] dist_a_r;
  logic [DIST_BITS-1:0] dist_b_r;
  logic [NA-1:0]        dist_ra;
  logic                 dist_we;
  logic [NA-1:0]        dist_wa;
  logic [DIST_BITS-1:0] dist_wd;

  logic [MAX_NODES-1:0] flags_r;
  logic [MAX_NODES-1:0] src_flags;
  logic [ECFG_W-1:0]    edge_idx_r;
  logic [NCFG_W-1:0]    pass_r;
  logic [NCFG_W-1:0]    node_r;
  logic                 neg_r;

  logic signed [DIST_BITS:0]   sum;
  logic [DIST_BITS-1:0]        cand;
  logic                        in_rng;
  logic                        hit;
  logic                        check_pass;

  logic                 out_valid_r;
  logic [NODE_W-1:0]    out_node_r;
  logic [DIST_BITS-1:0] out_dist_r;
  logic                 out_reached_r;
  logic                 out_neg_r;
  logic                 out_last_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_cnt_r <= NCFG_W'(1);
      edge_cnt_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_NODE_COUNT) begin
        node_cnt_r <= cfg_data[NCFG_W-1:0];
      end else if (cfg_index == REG_EDGE_COUNT) begin
        edge_cnt_r <= cfg_data[ECFG_W-1:0];
      end
    end
  end

  // Clamp counts to the store sizes; a node count of zero counts as one
  always_comb begin
    if (node_cnt_r == '0) begin
      n_eff = NCFG_W'(1);
    end else if (node_cnt_r > NCFG_W'(MAX_NODES)) begin
      n_eff = NCFG_W'(MAX_NODES);
    end else begin
      n_eff = node_cnt_r;
    end
    e_eff = (edge_cnt_r > ECFG_W'(ECAP)) ? ECFG_W'(ECAP) : edge_cnt_r;
  end

  // Edge store: written by load items, read at the edge counter
  always_ff @(posedge clk) begin
    if (cmd.load_edge && (32'(in_slot) < MAX_EDGES)) begin
      edge_mem[EA'(in_slot)] <= '{tail: in_from, head: in_to, weight: in_weight};
    end
    edge_rd_r <= edge_mem[EA'(edge_idx_r)];
  end

  // Relax unit: saturating candidate and improvement test
  always_comb begin
    sum = $signed({dist_a_r[DIST_BITS-1], dist_a_r})
        + $signed({{(DIST_BITS+1-WEIGHT_BITS){edge_rd_r.weight[WEIGHT_BITS-1]}},
                   edge_rd_r.weight});
    if (sum[DIST_BITS] != sum[DIST_BITS-1]) begin
      cand = sum[DIST_BITS] ? {1'b1, {(DIST_BITS-1){1'b0}}} : {1'b0, {(DIST_BITS-1){1'b1}}};
    end else begin
      cand = sum[DIST_BITS-1:0];
    end
    in_rng = (NCFG_W'(edge_rd_r.tail) < n_eff) && (NCFG_W'(edge_rd_r.head) < n_eff);
    hit = in_rng && flags_r[NA'(edge_rd_r.tail)]
        && (!flags_r[NA'(edge_rd_r.head)] || ($signed(cand) < $signed(dist_b_r)));
    check_pass = (pass_r == n_eff);
  end

  // Distance store port selection
  always_comb begin
    dist_ra = cmd.node_sel ? NA'(node_r) : NA'(edge_rd_r.tail);
    dist_we = cmd.run_start ? (NCFG_W'(in_source) < n_eff)
                            : (cmd.relax && hit && !check_pass);
    dist_wa = cmd.run_start ? NA'(in_source) : NA'(edge_rd_r.head);
    dist_wd = cmd.run_start ? '0 : cand;
  end

  // Reached flags at run start: only an in-range source
  assign src_flags = (NCFG_W'(in_source) < n_eff) ? (MAX_NODES'(1) << in_source) : '0;

  // Distance store: two registered reads, one write
  always_ff @(posedge clk) begin
    if (dist_we) begin
      dist_mem[dist_wa] <= dist_wd;
    end
    dist_a_r <= dist_mem[dist_ra];
    dist_b_r <= dist_mem[NA'(edge_rd_r.head)];
  end

  // Reached flags, pass and edge counters, cycle flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r    <= '0;
      edge_idx_r <= '0;
      pass_r     <= '0;
      node_r     <= '0;
      neg_r      <= 1'b0;
    end else begin
      if (cmd.run_start) begin
        flags_r    <= src_flags;
        edge_idx_r <= '0;
        pass_r     <= NCFG_W'(1);
        node_r     <= '0;
        neg_r      <= 1'b0;
      end
      if (cmd.relax) begin
        edge_idx_r <= edge_idx_r + ECFG_W'(1);
        if (hit && check_pass) begin
          neg_r <= 1'b1;
        end
        if (hit && !check_pass) begin
          flags_r[NA'(edge_rd_r.head)] <= 1'b1;
        end
      end
      if (cmd.pass_next) begin
        edge_idx_r <= '0;
        pass_r     <= pass_r + NCFG_W'(1);
      end
      if (cmd.node_load) begin
        node_r <= node_r + NCFG_W'(1);
      end
    end
  end

  // Output register: load a result, drop it when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.node_load || cmd.neg_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.node_load) begin
      out_node_r    <= NODE_W'(node_r);
      out_dist_r    <= flags_r[NA'(node_r)] ? dist_a_r : UNREACHED_DIST;
      out_reached_r <= flags_r[NA'(node_r)];
      out_neg_r     <= 1'b0;
      out_last_r    <= (node_r + NCFG_W'(1) == n_eff);
    end else if (cmd.neg_load) begin
      out_node_r    <= '0;
      out_dist_r    <= '0;
      out_reached_r <= 1'b0;
      out_neg_r     <= 1'b1;
      out_last_r    <= 1'b1;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_node    = out_node_r;
  assign out_dist    = out_dist_r;
  assign out_reached = out_reached_r;
  assign out_neg     = out_neg_r;
  assign out_last    = out_last_r;

  // Status to the controller
  always_comb begin
    sts.edges_none = (e_eff == '0);
    sts.edge_last  = (edge_idx_r + ECFG_W'(1) == e_eff);
    sts.check_pass = check_pass;
    sts.neg_found  = neg_r;
    sts.node_last  = (node_r + NCFG_W'(1) == n_eff);
    sts.out_free   = !out_valid_r || out_ready;
  end

  // A cycle result carries no distance and closes the run
  a_neg_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_neg_r) |-> (out_last_r && !out_reached_r && out_dist_r == '0))
    else $error("negative cycle result malformed");

  // An unreached node reports the unreachable distance
  a_unreached: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_neg_r && !out_reached_r) |-> (out_dist_r == UNREACHED_DIST))
    else $error("unreached node distance wrong");

  // Relaxation only runs inside the pass range
  a_pass_rng: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.relax |-> (pass_r != '0 && pass_r <= n_eff && edge_idx_r < e_eff))
    else $error("relax outside pass or edge range");

  // A distance write in a pass always comes from a reached tail
  a_wr_tail: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.relax && dist_we) |-> flags_r[NA'(edge_rd_r.tail)])
    else $error("distance written from unreached tail");

endmodule

FILE: rtl/bellman_ford_shortest_paths.sv
// Top level of the Bellman-Ford single-source shortest path block.
// Channels: in_chan takes items; kind 0 loads one edge (tail, head, signed weight)
// into edge_slot, kind 1 starts a run from source_node. cfg_chan writes
// node_count (index 0) and edge_count (index 1); it is always ready. The user
// must write it only while no run is in progress; the block does not enforce
// this. out_chan returns results. A load writes the edge store and returns
// nothing. A run makes n-1 relaxation passes plus a check pass, where n is
// node_count clamped to 1..MAX_NODES and e is edge_count clamped to the edge
// store size (no passes at all when e is 0); each edge goes through an edge
// store read, a distance store read, then relax and write back. Then one
// result per node (distance store read, output register load), the final one
// marked last; a negative cycle yields one flagged result instead.
// A new item is taken only once the previous run has loaded its final result.
// Stall: when out_chan.ready is low the output register holds its item and
// emission pauses. Reset: node_count 1, edge_count 0, no result pending; the
// edge store holds no defined data until loaded.
module bellman_ford_shortest_paths #(
  parameter int unsigned MAX_NODES = bfsp_pkg::DEF_MAX_NODES,
  parameter int unsigned MAX_EDGES = bfsp_pkg::DEF_MAX_EDGES
) (
  input  logic           clk,
  input  logic           rst_n,
  bfsp_in_if.sink        in_chan,
  bfsp_out_if.source     out_chan,
  bfsp_cfg_if.sink       cfg_chan
);
  import bfsp_pkg::*;

  bfsp_cmd_t cmd;
  bfsp_sts_t sts;

  // Configuration writes are always taken
  assign cfg_chan.ready = 1'b1;

  bfsp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_kind  (in_chan.kind),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bfsp_dp #(
    .MAX_NODES (MAX_NODES),
    .MAX_EDGES (MAX_EDGES)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_we      (cfg_chan.valid),
    .cfg_index   (cfg_chan.reg_index),
    .cfg_data    (cfg_chan.wr_data),
    .in_slot     (in_chan.edge_slot),
    .in_from     (in_chan.from_node),
    .in_to       (in_chan.to_node),
    .in_weight   (in_chan.edge_weight),
    .in_source   (in_chan.source_node),
    .out_ready   (out_chan.ready),
    .out_valid   (out_chan.valid),
    .out_node    (out_chan.node_index),
    .out_dist    (out_chan.distance),
    .out_reached (out_chan.reached),
    .out_neg     (out_chan.negative_cycle),
    .out_last    (out_chan.last)
  );

endmodule

FILE: sim/bellman_ford_shortest_paths_test.sv
// Self-checking testbench for the Bellman-Ford shortest path block.
module bellman_ford_shortest_paths_test;
  import bfsp_pkg::*;

  localparam int CYCLE_LIMIT   = 5_000_000;
  localparam int RANDOM_ITEMS  = 150;
  localparam int SETTLE_CYCLES = 8;
  localparam int REPORT_MAX    = 10;
  localparam int NODE_LAST     = (1 << NODE_W) - 1;
  localparam int SLOT_LAST     = (1 << SLOT_W) - 1;
  localparam int WEIGHT_MAX    = (1 << (WEIGHT_BITS - 1)) - 1;
  localparam int WEIGHT_MIN    = -WEIGHT_MAX - 1;
  localparam int NCFG_MAX      = (1 << NCFG_W) - 1;
  localparam int ECFG_MAX      = (1 << ECFG_W) - 1;
  localparam longint DIST_MAX  = (longint'(1) << (DIST_BITS - 1)) - 1;
  localparam longint DIST_MIN  = -DIST_MAX - 1;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = REG_EDGE_COUNT + 1'b1;

  typedef struct packed {
    logic                   kind;
    logic [SLOT_W-1:0]      edge_slot;
    logic [NODE_W-1:0]      from_node;
    logic [NODE_W-1:0]      to_node;
    logic [WEIGHT_BITS-1:0] edge_weight;
    logic [NODE_W-1:0]      source_node;
  } bf_item_t;

  typedef struct packed {
    logic [NODE_W-1:0]    node_index;
    logic [DIST_BITS-1:0] distance;
    logic                 reached;
    logic                 negative_cycle;
    logic                 last;
  } dist_rpt_t;

  // Edge pattern used for random loads within a phase
  typedef enum {SHAPE_DAG, SHAPE_NONNEG, SHAPE_MIXED, SHAPE_WILD} graph_shape_t;

  // Shortest path predictor and queue of distance reports still due
  class distance_board_t;
    logic [NODE_W-1:0] edge_from [DEF_MAX_EDGES];
    logic [NODE_W-1:0] edge_to   [DEF_MAX_EDGES];
    longint            edge_wt   [DEF_MAX_EDGES];
    longint            node_dist [DEF_MAX_NODES];
    bit                node_hit  [DEF_MAX_NODES];
    logic [NCFG_W-1:0] node_cfg;
    logic [ECFG_W-1:0] edge_cfg;
    dist_rpt_t         expected_dists[$];
    int                errors;
    int                checked;
    int                neg_seen;

    function new();
      node_cfg = NCFG_W'(1);
      edge_cfg = '0;
      errors   = 0;
      checked  = 0;
      neg_seen = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_NODE_COUNT) node_cfg = data[NCFG_W-1:0];
      else if (idx == REG_EDGE_COUNT) edge_cfg = data[ECFG_W-1:0];
    endfunction

    // Relax edge j; report whether the head improves (or would improve)
    function bit try_relax(int j, int n, bit apply);
      int     u;
      int     v;
      longint cand;
      u = edge_from[j];
      v = edge_to[j];
      if (u >= n || v >= n || !node_hit[u]) return 1'b0;
      cand = node_dist[u] + edge_wt[j];
      if (cand > DIST_MAX) cand = DIST_MAX;
      else if (cand < DIST_MIN) cand = DIST_MIN;
      if (node_hit[v] && cand >= node_dist[v]) return 1'b0;
      if (apply) begin
        node_dist[v] = cand;
        node_hit[v]  = 1'b1;
      end
      return 1'b1;
    endfunction

    // Note an accepted item: store an edge, or solve a run and queue its reports
    function void take_item(bf_item_t it);
      int        n;
      int        e;
      int        src;
      bit        neg;
      dist_rpt_t r;
      if (it.kind == KIND_LOAD) begin
        edge_from[it.edge_slot] = it.from_node;
        edge_to[it.edge_slot]   = it.to_node;
        edge_wt[it.edge_slot]   = longint'($signed(it.edge_weight));
        return;
      end
      n = node_cfg;
      if (n < 1) n = 1;
      if (n > int'(DEF_MAX_NODES)) n = DEF_MAX_NODES;
      e = edge_cfg;
      if (e > int'(DEF_MAX_EDGES)) e = DEF_MAX_EDGES;
      src = it.source_node;
      for (int i = 0; i < int'(DEF_MAX_NODES); i++) begin
        node_dist[i] = longint'(UNREACHED_DIST);
        node_hit[i]  = 1'b0;
      end
      if (src < n) begin
        node_dist[src] = 0;
        node_hit[src]  = 1'b1;
      end
      for (int p = 1; p < n; p++)
        for (int j = 0; j < e; j++) void'(try_relax(j, n, 1'b1));
      neg = 1'b0;
      for (int j = 0; j < e; j++)
        if (try_relax(j, n, 1'b0)) neg = 1'b1;
      if (neg) begin
        r = '0;
        r.negative_cycle = 1'b1;
        r.last = 1'b1;
        expected_dists.push_back(r);
        return;
      end
      for (int i = 0; i < n; i++) begin
        r.node_index     = NODE_W'(i);
        r.distance       = node_hit[i] ? DIST_BITS'(node_dist[i]) : UNREACHED_DIST;
        r.reached        = node_hit[i];
        r.negative_cycle = 1'b0;
        r.last           = (i == n - 1);
        expected_dists.push_back(r);
      end
    endfunction

    // Compare one accepted report with the oldest one due
    function void check_result(dist_rpt_t got);
      dist_rpt_t want;
      checked++;
      if (got.negative_cycle) neg_seen++;
      if (expected_dists.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("ERROR: unexpected report node %0d dist %0d reached %0b neg %0b last %0b",
                   got.node_index, $signed(got.distance), got.reached,
                   got.negative_cycle, got.last);
        return;
      end
      want = expected_dists.pop_front();
      if (got.node_index !== want.node_index || got.distance !== want.distance ||
          got.reached !== want.reached || got.negative_cycle !== want.negative_cycle ||
          got.last !== want.last) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("ERROR: report %0d expected node %0d dist %0d reached %0b neg %0b last %0b, %s",
                   checked, want.node_index, $signed(want.distance), want.reached,
                   want.negative_cycle, want.last,
                   $sformatf("got node %0d dist %0d reached %0b neg %0b last %0b",
                             got.node_index, $signed(got.distance), got.reached,
                             got.negative_cycle, got.last));
      end
    endfunction
  endclass

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  int unsigned cycle_cnt = 0;

  bfsp_in_if  in_chan();
  bfsp_out_if out_chan();
  bfsp_cfg_if cfg_chan();

  distance_board_t board = new();
  dist_rpt_t     seen_rpt;
  bit            slot_loaded [DEF_MAX_EDGES];
  bit            no_idle = 1'b0;
  int            random_count = 0;
  int            n_runs = 0;
  int            n_loads = 0;
  int            cfg_writes = 0;

  bellman_ford_shortest_paths i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  // Check every report taken by the sink
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      seen_rpt = {out_chan.node_index, out_chan.distance, out_chan.reached,
                  out_chan.negative_cycle, out_chan.last};
      board.check_result(seen_rpt);
    end
  end

  // Abort a hung run
  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("TIMEOUT after %0d cycles, %0d reports still due", cycle_cnt,
             board.expected_dists.size());
    $display("bellman_ford_shortest_paths verification failed");
    $finish;
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Pace the result sink: bursts of ready, then stalls
  initial begin : out_pacer
    int burst;
    int gap;
    out_chan.ready = 1'b0;
    forever begin
      burst = $urandom_range(1, 24);
      repeat (burst) begin
        @(negedge clk);
        out_chan.ready = 1'b1;
      end
      gap = no_idle ? 0 : pick_gap();
      repeat (gap) begin
        @(negedge clk);
        out_chan.ready = 1'b0;
      end
    end
  end

  function automatic int eff_nodes();
    int n;
    n = board.node_cfg;
    if (n < 1) n = 1;
    if (n > int'(DEF_MAX_NODES)) n = DEF_MAX_NODES;
    return n;
  endfunction

  function automatic int eff_edges();
    int e;
    e = board.edge_cfg;
    if (e > int'(DEF_MAX_EDGES)) e = DEF_MAX_EDGES;
    return e;
  endfunction

  // Mostly a node in the graph, now and then any node
  function automatic int pick_node(int n);
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, NODE_LAST);
    return $urandom_range(0, n - 1);
  endfunction

  function automatic int pick_slot();
    int e;
    e = eff_edges();
    if (e > 0 && $urandom_range(0, 9) < 8) return $urandom_range(0, e - 1);
    return $urandom_range(0, SLOT_LAST);
  endfunction

  // Fill every field at random; fields the kind ignores stay random
  function automatic bf_item_t random_item();
    bf_item_t it;
    it.kind        = $urandom_range(0, 1);
    it.edge_slot   = SLOT_W'($urandom);
    it.from_node   = NODE_W'($urandom);
    it.to_node     = NODE_W'($urandom);
    it.edge_weight = WEIGHT_BITS'($urandom);
    it.source_node = NODE_W'($urandom);
    return it;
  endfunction

  function automatic bf_item_t make_load(int slot, graph_shape_t shape);
    bf_item_t it;
    int       n;
    int       a;
    n = eff_nodes();
    it = random_item();
    it.kind      = KIND_LOAD;
    it.edge_slot = SLOT_W'(slot);
    it.from_node = NODE_W'(pick_node(n));
    it.to_node   = NODE_W'(pick_node(n));
    case (shape)
      SHAPE_DAG: begin
        if (n >= 2) begin
          a = $urandom_range(0, n - 2);
          it.from_node = NODE_W'(a);
          it.to_node   = NODE_W'($urandom_range(a + 1, n - 1));
        end
      end
      SHAPE_NONNEG: begin
        it.edge_weight = WEIGHT_BITS'($urandom_range(0, WEIGHT_MAX));
      end
      SHAPE_MIXED: begin
        if ($urandom_range(0, 9) < 8) it.edge_weight = WEIGHT_BITS'($urandom_range(0, 1000));
        else it.edge_weight = WEIGHT_BITS'(-int'($urandom_range(1, 50)));
      end
      default: ;
    endcase
    return it;
  endfunction

  function automatic bf_item_t make_run();
    bf_item_t it;
    it = random_item();
    it.kind = KIND_RUN;
    it.source_node = NODE_W'(pick_node(eff_nodes()));
    return it;
  endfunction

  // Present one item at the falling edge, hold it until taken
  task automatic send_item(bf_item_t it);
    int gap;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      in_chan.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_chan.kind        = it.kind;
    in_chan.edge_slot   = it.edge_slot;
    in_chan.from_node   = it.from_node;
    in_chan.to_node     = it.to_node;
    in_chan.edge_weight = it.edge_weight;
    in_chan.source_node = it.source_node;
    in_chan.valid       = 1'b1;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    board.take_item(it);
    if (it.kind == KIND_LOAD) begin
      slot_loaded[it.edge_slot] = 1'b1;
      n_loads++;
    end else begin
      n_runs++;
    end
    @(negedge clk);
  endtask

  task automatic load_edge(int slot, int from_n, int to_n, int weight);
    bf_item_t it;
    it = random_item();
    it.kind        = KIND_LOAD;
    it.edge_slot   = SLOT_W'(slot);
    it.from_node   = NODE_W'(from_n);
    it.to_node     = NODE_W'(to_n);
    it.edge_weight = WEIGHT_BITS'(weight);
    send_item(it);
  endtask

  task automatic run_from(int src);
    bf_item_t it;
    it = random_item();
    it.kind        = KIND_RUN;
    it.source_node = NODE_W'(src);
    send_item(it);
  endtask

  // Hold the sender until every due report has come and the block settles
  task automatic wait_idle();
    in_chan.valid = 1'b0;
    while (board.expected_dists.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_chan.reg_index = idx;
    cfg_chan.wr_data   = data;
    cfg_chan.valid     = 1'b1;
    @(posedge clk);
    while (!cfg_chan.ready) @(posedge clk);
    board.set_reg(idx, data);
    cfg_writes++;
    @(negedge clk);
  endtask

  // Sometimes set the bits above the register width
  function automatic logic [CFG_DATA_W-1:0] pad_data(int value, int keep);
    if ($urandom_range(0, 9) < 3)
      return (CFG_DATA_W'($urandom) << keep) | CFG_DATA_W'(value);
    return CFG_DATA_W'(value);
  endfunction

  task automatic set_config(int nodes, int edges);
    write_reg(REG_NODE_COUNT, pad_data(nodes, NCFG_W));
    write_reg(REG_EDGE_COUNT, pad_data(edges, ECFG_W));
    if ($urandom_range(0, 3) == 0)
      write_reg(CFG_IDX_W'($urandom_range(REG_FIRST_UNUSED, (1 << CFG_IDX_W) - 1)),
                CFG_DATA_W'($urandom));
    cfg_chan.valid = 1'b0;
  endtask

  // Load every slot the current edge count reads that needs it
  task automatic fill_slots(graph_shape_t shape, bit refill);
    for (int s = 0; s < eff_edges(); s++)
      if (refill || !slot_loaded[s]) send_item(make_load(s, shape));
  endtask

  task automatic directed_items();
    // Reset sizes: one node, no edges; source inside and outside the graph
    run_from(0);
    run_from(NODE_LAST);

    // Short chain with an extreme weight and an edge leaving the graph
    wait_idle();
    set_config(4, 4);
    load_edge(0, 0, 1, 5);
    load_edge(1, 1, 2, -3);
    load_edge(2, 2, 3, WEIGHT_MAX);
    load_edge(3, 3, NODE_LAST, WEIGHT_MIN);
    run_from(0);
    run_from(2);
    run_from(NODE_LAST);

    // Close a negative loop; only a source that reaches it sees it
    load_edge(3, 2, 1, -10);
    run_from(0);
    run_from(3);

    // Node count above the store size, loop that drives distances to the floor
    wait_idle();
    set_config(NCFG_MAX, 6);
    for (int s = 0; s < 6; s++)
      load_edge(s, s % 2, (s + 1) % 2, WEIGHT_MIN);
    run_from(0);
    load_edge(SLOT_LAST, NODE_LAST, NODE_LAST, WEIGHT_MAX);

    // Node count of zero
    wait_idle();
    set_config(0, 0);
    run_from(0);
  endtask

  task automatic random_phases();
    int           phase;
    int           items;
    int           run_pct;
    int           roll;
    graph_shape_t shape;
    phase = 0;
    while (random_count < RANDOM_ITEMS) begin
      wait_idle();
      no_idle = ($urandom_range(0, 3) == 0);
      shape   = graph_shape_t'($urandom_range(0, 3));
      run_pct = 40;
      if (phase == 1) begin
        // Full edge store with both registers at their top codes
        shape = SHAPE_DAG;
        set_config(NCFG_MAX, ECFG_MAX);
        items = 4;
        run_pct = 50;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 25) begin
          set_config($urandom_range(9, 40), $urandom_range(17, 48));
          items = 8;
        end else if (roll < 35) begin
          set_config(0, $urandom_range(0, 16));
          items = $urandom_range(8, 16);
        end else if (roll < 42) begin
          set_config($urandom_range(DEF_MAX_NODES + 1, NCFG_MAX), $urandom_range(0, 8));
          items = 4;
        end else begin
          set_config($urandom_range(1, 8), $urandom_range(0, 16));
          items = $urandom_range(8, 16);
        end
      end
      fill_slots(shape, 1'b1);
      for (int k = 0; k < items; k++) begin
        if ($urandom_range(0, 9) == 0) wait_idle();
        if ($urandom_range(0, 99) < run_pct) begin
          fill_slots(shape, 1'b0);
          send_item(make_run());
        end else begin
          send_item(make_load(pick_slot(), shape));
        end
        random_count++;
      end
      phase++;
    end
  endtask

  initial begin
    in_chan.valid       = 1'b0;
    in_chan.kind        = KIND_LOAD;
    in_chan.edge_slot   = '0;
    in_chan.from_node   = '0;
    in_chan.to_node     = '0;
    in_chan.edge_weight = '0;
    in_chan.source_node = '0;
    cfg_chan.valid      = 1'b0;
    cfg_chan.reg_index  = REG_NODE_COUNT;
    cfg_chan.wr_data    = '0;
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    directed_items();
    random_phases();

    // Drain, then watch for stray reports
    wait_idle();
    repeat (4 * SETTLE_CYCLES) @(negedge clk);

    $display("Run covered %0d shortest path runs, %0d edge loads, %0d register writes.",
             n_runs, n_loads, cfg_writes);
    $display("Checked %0d reports (%0d negative cycle flags), %0d mismatches.",
             board.checked, board.neg_seen, board.errors);
    if (board.errors == 0 && board.expected_dists.size() == 0) begin
      $display("bellman_ford_shortest_paths verification clean");
    end else begin
      $display("bellman_ford_shortest_paths verification failed");
    end
    $finish;
  end

endmodule
